// ===== rtl/core/dvt_pkg.sv =====
package dvt_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  PAYLOAD_MASK  = 8'h7F;
    localparam logic [7:0]  CONT_BIT      = 8'h80;
    localparam logic [31:0] APPEND_CODE   = 32'hFFFF_FFFF;
    localparam logic [3:0]  VARINT_MAX    = 4'd5;
    localparam logic [3:0]  ABS_LAST_IDX  = 4'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        point_time;
        logic signed [31:0] point_lat;
        logic signed [31:0] point_lon;
        logic               status;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_ABS   = 2'd0,
        CMD_DELTA = 2'd1,
        CMD_ERR   = 2'd2
    } cmd_kind_t;

    // abs: a/b/c are the point; delta: time delta, lat code, lon code
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_ctl_t;

endpackage

// ===== rtl/core/dvt_front.sv =====
module dvt_front
    import dvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output q_wr_ctl_t wr_ctl,
    output cmd_t      cmd,
    input  logic      q_full
);

    typedef enum logic [1:0] {
        PH_ABS  = 2'd0,
        PH_TIME = 2'd1,
        PH_LAT  = 2'd2,
        PH_LON  = 2'd3
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       bc_reg, bc_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      tdelta_reg, tdelta_next;
    logic [31:0]      latc_reg, latc_next;
    logic [11:0][7:0] abs_reg, abs_next;
    logic             halted_reg, halted_next;

    logic             accept;
    logic             push;
    phase_t           phase_e;
    logic [3:0]       bc_e;
    logic [31:0]      acc_e;
    logic             halted_e;
    logic [31:0]      acc_add;
    logic [31:0]      acc_new;
    logic [3:0]       lane;
    logic [3:0]       bc_inc;
    logic [7:0]       b;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.data_byte;
    assign bc_inc   = bc_e + 4'd1;

    assign wr_ctl.push = push;
    assign wr_ctl.full = q_full;

    always_comb begin
        // new file drops any partial record and clears the halt
        phase_e  = phase_reg;
        bc_e     = bc_reg;
        acc_e    = acc_reg;
        halted_e = halted_reg;
        if (in_data.new_file) begin
            phase_e  = PH_ABS;
            bc_e     = 4'd0;
            acc_e    = 32'd0;
            halted_e = 1'b0;
        end

        case (bc_e[2:0])
            3'd0:    acc_add = {25'd0, b[6:0]};
            3'd1:    acc_add = {18'd0, b[6:0], 7'd0};
            3'd2:    acc_add = {11'd0, b[6:0], 14'd0};
            3'd3:    acc_add = {4'd0, b[6:0], 21'd0};
            3'd4:    acc_add = {b[3:0], 28'd0};
            default: acc_add = 32'd0;
        endcase
        acc_new = acc_e | acc_add;

        // lanes above the lon word fold back onto it
        lane = (bc_e < 4'd8) ? bc_e : {2'b10, bc_e[1:0]};

        phase_next  = phase_e;
        bc_next     = bc_e;
        acc_next    = acc_e;
        tdelta_next = tdelta_reg;
        latc_next   = latc_reg;
        abs_next    = abs_reg;
        halted_next = halted_e;
        push        = 1'b0;
        cmd         = '{kind: CMD_ERR, a: 32'd0, b: 32'd0, c: 32'd0};

        if (!halted_e) begin
            if (phase_e == PH_ABS) begin
                abs_next[lane] = b;
                bc_next        = bc_inc;
                if (bc_e >= ABS_LAST_IDX) begin
                    bc_next    = 4'd0;
                    acc_next   = 32'd0;
                    phase_next = PH_TIME;
                    push       = 1'b1;
                    cmd.kind   = CMD_ABS;
                    cmd.a      = abs_next[3:0];
                    cmd.b      = abs_next[7:4];
                    cmd.c      = abs_next[11:8];
                end
            end else if (bc_e >= VARINT_MAX) begin
                halted_next = 1'b1;
                push        = 1'b1;
            end else if ((b & CONT_BIT) != 8'd0) begin
                acc_next = acc_new;
                bc_next  = bc_inc;
                if (bc_inc >= VARINT_MAX) begin
                    halted_next = 1'b1;
                    bc_next     = 4'd0;
                    acc_next    = 32'd0;
                    push        = 1'b1;
                end
            end else begin
                acc_next = 32'd0;
                bc_next  = 4'd0;
                case (phase_e)
                    PH_TIME: begin
                        if (acc_new == APPEND_CODE) begin
                            phase_next = PH_ABS;
                        end else begin
                            tdelta_next = acc_new;
                            phase_next  = PH_LAT;
                        end
                    end
                    PH_LAT: begin
                        latc_next  = acc_new;
                        phase_next = PH_LON;
                    end
                    default: begin
                        phase_next = PH_TIME;
                        push       = 1'b1;
                        cmd.kind   = CMD_DELTA;
                        cmd.a      = tdelta_reg;
                        cmd.b      = latc_reg;
                        cmd.c      = acc_new;
                    end
                endcase
            end
        end

        if (!accept) begin
            phase_next  = phase_reg;
            bc_next     = bc_reg;
            acc_next    = acc_reg;
            tdelta_next = tdelta_reg;
            latc_next   = latc_reg;
            abs_next    = abs_reg;
            halted_next = halted_reg;
            push        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ABS;
            bc_reg     <= 4'd0;
            acc_reg    <= 32'd0;
            tdelta_reg <= 32'd0;
            latc_reg   <= 32'd0;
            abs_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            acc_reg    <= acc_next;
            tdelta_reg <= tdelta_next;
            latc_reg   <= latc_next;
            abs_reg    <= abs_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== rtl/core/dvt_queue.sv =====
module dvt_queue
    import dvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_wr_ctl_t wr_ctl,
    input  cmd_t      wr_cmd,
    output logic      full,
    output logic      not_empty,
    input  logic      pop,
    output cmd_t      rd_cmd,
    output logic [QPTR_W:0] count
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign rd_cmd    = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        // depth is a power of two, pointers wrap on their own
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_ctl.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({wr_ctl.push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/core/dvt_back.sv =====
module dvt_back
    import dvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    function automatic logic [31:0] unzigzag(input logic [31:0] v);
        unzigzag = {1'b0, v[31:1]} ^ {32{v[0]}};
    endfunction

    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] last_lat_reg, last_lat_next;
    logic [31:0] last_lon_reg, last_lon_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        last_time_next = last_time_reg;
        last_lat_next  = last_lat_reg;
        last_lon_next  = last_lon_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop) begin
            out_valid_next = 1'b1;
            case (q_cmd.kind)
                CMD_ABS: begin
                    last_time_next = q_cmd.a;
                    last_lat_next  = q_cmd.b;
                    last_lon_next  = q_cmd.c;
                end
                CMD_DELTA: begin
                    last_time_next = last_time_reg + q_cmd.a;
                    last_lat_next  = last_lat_reg + unzigzag(q_cmd.b);
                    last_lon_next  = last_lon_reg + unzigzag(q_cmd.c);
                end
                default: begin
                end
            endcase
            if (q_cmd.kind == CMD_ABS || q_cmd.kind == CMD_DELTA) begin
                out_next.point_time = last_time_next;
                out_next.point_lat  = last_lat_next;
                out_next.point_lon  = last_lon_next;
                out_next.status     = 1'b0;
            end else begin
                out_next = '{point_time: 32'd0, point_lat: 32'sd0,
                             point_lon: 32'sd0, status: 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= 32'd0;
            last_lat_reg  <= 32'd0;
            last_lon_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            last_time_reg <= last_time_next;
            last_lat_reg  <= last_lat_next;
            last_lon_reg  <= last_lon_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

// ===== rtl/core/delta_varint_track_decoder.sv =====
// Decodes a delta/varint track file fed one byte per word on s_data and
// returns one point on m_data for each finished record, or one error word
// (status 1, zero point) for a varint running past five bytes, after which
// bytes are dropped until a word with new_file set. A byte is taken every
// cycle as long as the two-word command queue between the byte parser and
// the point accumulator has room; a point reaches m_valid through the queue
// write and then the output register of the accumulator, and waits in the
// queue while m_ready holds the output register.
module delta_varint_track_decoder
    import dvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    q_wr_ctl_t       wr_ctl;
    cmd_t            wr_cmd;
    cmd_t            rd_cmd;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;
    logic [QPTR_W:0] q_count;

    dvt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .wr_ctl   (wr_ctl),
        .cmd      (wr_cmd),
        .q_full   (q_full)
    );

    dvt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_ctl    (wr_ctl),
        .wr_cmd    (wr_cmd),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .rd_cmd    (rd_cmd),
        .count     (q_count)
    );

    dvt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_cmd     (rd_cmd),
        .pop       (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ctl.push |-> !wr_ctl.full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_error_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.point_time == 32'd0 && m_data.point_lat == 32'sd0 &&
             m_data.point_lon == 32'sd0))
        else $error("error word carries a point");

    a_pop_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("popped command did not reach the output");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dvt_pkg::*;

    typedef enum logic [1:0] {
        REC_ABS,
        REC_TIME,
        REC_LAT,
        REC_LON
    } rec_part_t;

    localparam int STREAM_BYTES   = 650;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    localparam int IDLE_PCT       = 31;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic      calm;

    in_word_t  track_bytes[$];
    out_word_t expected_points[$];
    int        errors         = 0;
    int        accepted_bytes = 0;
    int        idle_cycles    = 0;

    // shadow of the decoder state
    rec_part_t   part      = REC_ABS;
    logic [3:0]  nbytes    = '0;
    logic [31:0] accum     = '0;
    logic [31:0] time_step = '0;
    logic [31:0] lat_zz    = '0;
    logic [31:0] cur_time  = '0;
    logic [31:0] cur_lat   = '0;
    logic [31:0] cur_lon   = '0;
    bit          stopped   = 1'b0;

    delta_varint_track_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (accepted_bytes >= 250) && (accepted_bytes < 400);

    function automatic logic [31:0] zigzag_decode(input logic [31:0] v);
        return (v >> 1) ^ {32{v[0]}};
    endfunction

    function automatic void decode_byte(input in_word_t w, output bit has_point,
                                        output out_word_t pt);
        logic [4:0]  sh;
        logic [31:0] value;
        has_point = 1'b0;
        pt        = '0;
        if (w.new_file) begin
            stopped = 1'b0;
            part    = REC_ABS;
            nbytes  = '0;
            accum   = '0;
        end
        if (stopped)
            return;
        if (part == REC_ABS) begin
            sh = {nbytes[1:0], 3'b000};
            if (nbytes < 4)
                cur_time[sh +: 8] = w.data_byte;
            else if (nbytes < 8)
                cur_lat[sh +: 8] = w.data_byte;
            else
                cur_lon[sh +: 8] = w.data_byte;
            if (nbytes == ABS_LAST_IDX) begin
                nbytes    = '0;
                accum     = '0;
                part      = REC_TIME;
                has_point = 1'b1;
                pt        = '{cur_time, cur_lat, cur_lon, 1'b0};
            end else begin
                nbytes = nbytes + 1'b1;
            end
            return;
        end
        // payload bits past bit 31 fall off the shift
        accum = accum | (32'(w.data_byte & PAYLOAD_MASK) << (7 * nbytes));
        if ((w.data_byte & CONT_BIT) != 0) begin
            nbytes = nbytes + 1'b1;
            if (nbytes >= VARINT_MAX) begin
                stopped   = 1'b1;
                nbytes    = '0;
                accum     = '0;
                has_point = 1'b1;
                pt        = '0;
                pt.status = 1'b1;
            end
            return;
        end
        value  = accum;
        accum  = '0;
        nbytes = '0;
        case (part)
            REC_TIME: begin
                if (value == APPEND_CODE) begin
                    part = REC_ABS;
                end else begin
                    time_step = value;
                    part      = REC_LAT;
                end
            end
            REC_LAT: begin
                lat_zz = value;
                part   = REC_LON;
            end
            default: begin
                cur_time  = cur_time + time_step;
                cur_lat   = cur_lat + zigzag_decode(lat_zz);
                cur_lon   = cur_lon + zigzag_decode(value);
                part      = REC_TIME;
                has_point = 1'b1;
                pt        = '{cur_time, cur_lat, cur_lon, 1'b0};
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit nf = 1'b0);
        in_word_t w;
        w.data_byte = b;
        w.new_file  = nf;
        track_bytes.push_back(w);
    endtask

    task automatic push_abs(input logic [31:0] t, input logic [31:0] la,
                            input logic [31:0] lo, input bit nf);
        logic [95:0] rec;
        rec = {lo, la, t};
        for (int i = 0; i < 12; i++)
            push_byte(rec[8*i +: 8], nf && (i == 0));
    endtask

    // len is raised to the shortest encoding that holds the value
    task automatic push_varint(input logic [31:0] value, input int len);
        logic [7:0] b;
        int         need;
        need = 1;
        while (need < 5 && (value >> (7 * need)) != 0)
            need++;
        if (len < need)
            len = need;
        for (int i = 0; i < len; i++) begin
            b = 8'((value >> (7 * i)) & 32'h7F);
            if (i == 4)
                b[6:4] = 3'($urandom_range(0, 7));
            b[7] = (i < len - 1);
            push_byte(b);
        end
    endtask

    task automatic push_overlong();
        repeat (5) push_byte(8'($urandom_range(0, 255)) | CONT_BIT);
    endtask

    function automatic logic [31:0] random_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 127);
        if (r < 8)
            return $urandom_range(0, 1 << 21);
        return $urandom;
    endfunction

    function automatic int random_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 1;
    endfunction

    always @(posedge aclk) begin : driver
        bit        got;
        out_word_t pt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data, got, pt);
                if (got)
                    expected_points.push_back(pt);
                accepted_bytes <= accepted_bytes + 1;
            end
            if (!s_valid || s_ready) begin
                if (track_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= track_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected word: time %0d lat %0d lon %0d status %0d",
                           m_data.point_time, m_data.point_lat, m_data.point_lon,
                           m_data.status);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_data.point_time !== want.point_time) begin
                        $error("point_time: expected %0d, got %0d",
                               want.point_time, m_data.point_time);
                        errors++;
                    end
                    if (m_data.point_lat !== want.point_lat) begin
                        $error("point_lat: expected %0d, got %0d",
                               want.point_lat, m_data.point_lat);
                        errors++;
                    end
                    if (m_data.point_lon !== want.point_lon) begin
                        $error("point_lon: expected %0d, got %0d",
                               want.point_lon, m_data.point_lon);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errors++;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int n;
        int dropped;
        dropped = 0;

        // first record after reset is absolute without new_file, extreme values
        push_abs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        // five byte varints: padded small delta, largest zigzag codes
        push_varint(32'h0000_0001, 5);
        push_varint(32'hFFFF_FFFE, 5);
        push_varint(32'hFFFF_FFFF, 5);
        // over-long time varint, then a byte that the halted decoder drops
        push_overlong();
        push_byte(8'h00);
        dropped++;
        push_abs($urandom, $urandom, $urandom, 1'b1);
        // append marker then a fresh absolute record, then an all-zero delta
        push_varint(APPEND_CODE, 5);
        push_abs(32'h0, 32'h0, 32'h0, 1'b0);
        push_varint(32'h0, 1);
        push_varint(32'h0, 1);
        push_varint(32'h0, 1);

        while (track_bytes.size() - dropped < STREAM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                push_varint(random_code(), random_len());
                push_varint(random_code(), random_len());
                push_varint(random_code(), random_len());
            end else if (pick < 72) begin
                push_varint(APPEND_CODE, 5);
                push_abs($urandom, $urandom, $urandom, 1'b0);
            end else if (pick < 80) begin
                push_abs($urandom, $urandom, $urandom, 1'b1);
            end else if (pick < 86) begin
                push_overlong();
                n = $urandom_range(0, 4);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
                dropped += n;
                push_abs($urandom, $urandom, $urandom, 1'b1);
            end else if (pick < 93) begin
                // record cut short by a new file
                push_varint(random_code(), random_len());
                if ($urandom_range(0, 1))
                    push_varint(random_code(), random_len());
                push_byte(8'($urandom_range(0, 255)) | CONT_BIT);
                push_abs($urandom, $urandom, $urandom, 1'b1);
            end else begin
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (track_bytes.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dvt_pkg.sv
rtl/core/dvt_front.sv
rtl/core/dvt_queue.sv
rtl/core/dvt_back.sv
rtl/core/delta_varint_track_decoder.sv
tb/testbench.sv
